@@ src/hrp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hrp_pkg
// Shared types, constants and the digit decode for the hex record parser.
// ----------------------------------------------------------------------------
package hrp_pkg;

  localparam int unsigned HRP_MAX_DATA = 16;

  localparam logic [7:0] CHAR_START = 8'h3A;  // ':'
  localparam logic [7:0] CHAR_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] ALPHA_BIAS = 8'd87;  // 'a' - 10

  typedef enum logic [2:0] {
    PH_WAIT   = 3'd0,
    PH_COUNT  = 3'd1,
    PH_ADDRHI = 3'd2,
    PH_ADDRLO = 3'd3,
    PH_TYPE   = 3'd4,
    PH_DATA   = 3'd5,
    PH_CSUM   = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    ST_CSUM_OK  = 2'd0,
    ST_CSUM_ERR = 2'd1,
    ST_OVERLONG = 2'd2
  } status_t;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_RECORD = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [3:0]  offset;
    logic [15:0] load_address;
    logic [7:0]  rec_type;
    logic [7:0]  length;
    logic [1:0]  status;
  } result_t;

  // Any character decodes to a nibble; non-hex characters are not trapped.
  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] d;
    if (c <= CHAR_NINE) d = c - CHAR_ZERO;
    else                d = c - ALPHA_BIAS;
    return d[3:0];
  endfunction

endpackage
`default_nettype wire

@@ src/hex_record_parser.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hex_record_parser
// Intel HEX style record decoder: one ASCII character per word in, data
// bytes and end-of-record status words out.
// ----------------------------------------------------------------------------
//
//  channel | ports                                   | dir | word
//  --------+-----------------------------------------+-----+--------------------
//  in      | in_valid, in_stall, in_char_in          | in  | one character
//  out     | out_valid, out_stall, out_kind ...      | out | data byte / record
//
// One character per cycle while in_stall is low. Each character is decoded in a
// single pass from the phase registers to the output register, or to the skid
// slot while the output stalls.
// Reset (rst_n low, synchronous) returns to waiting for ':' and empties the
// output register and skid slot.
// A stall on the output parks one result in a skid slot; in_stall is high
// exactly while that slot is full.
// ----------------------------------------------------------------------------
module hex_record_parser import hrp_pkg::*; #(
  parameter int unsigned MAX_DATA = HRP_MAX_DATA
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_char_in,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_kind,
  output logic [7:0]       out_data_byte,
  output logic [3:0]       out_offset,
  output logic [15:0]      out_load_address,
  output logic [7:0]       out_rec_type,
  output logic [7:0]       out_length,
  output logic [1:0]       out_status
);

  // Limit as an 8-bit compare operand (range is 1..255).
  localparam logic [7:0] MaxData = 8'(MAX_DATA);

  // Parser state
  phase_t      phase_r, phase_nxt;
  logic [3:0]  high_nibble_r, high_nibble_nxt;
  logic        digit_phase_r, digit_phase_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  index_r, index_nxt;

  // Output register and skid slot
  logic        out_valid_r;
  result_t     out_r;
  logic        skid_valid_r;
  result_t     skid_r;

  logic        in_take;
  logic        out_take;
  logic        res_valid;
  result_t     res;

  logic [3:0]  nib;
  logic [7:0]  byte_val;
  logic [7:0]  index_inc;

  assign in_stall  = skid_valid_r;
  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;

  assign nib       = nibble_of(in_char_in);
  assign byte_val  = {high_nibble_r, nib};
  assign index_inc = index_r + 8'd1;

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (in_take) begin
      unique case (phase_r)
        PH_WAIT:   phase_nxt = (in_char_in == CHAR_START) ? PH_COUNT : PH_WAIT;
        PH_COUNT:  if (digit_phase_r) phase_nxt = PH_ADDRHI;
        PH_ADDRHI: if (digit_phase_r) phase_nxt = PH_ADDRLO;
        PH_ADDRLO: if (digit_phase_r) phase_nxt = PH_TYPE;
        PH_TYPE: begin
          if (digit_phase_r) phase_nxt = (count_r == 8'd0) ? PH_CSUM : PH_DATA;
        end
        PH_DATA: begin
          if (digit_phase_r && (index_inc >= count_r)) phase_nxt = PH_CSUM;
        end
        PH_CSUM:   if (digit_phase_r) phase_nxt = PH_WAIT;
        default:   phase_nxt = PH_WAIT;
      endcase
    end
  end

  // Datapath and result word
  always_comb begin
    high_nibble_nxt = high_nibble_r;
    digit_phase_nxt = digit_phase_r;
    count_nxt       = count_r;
    addr_nxt        = addr_r;
    type_nxt        = type_r;
    sum_nxt         = sum_r;
    index_nxt       = index_r;
    res_valid       = 1'b0;

    res.kind         = KIND_DATA;
    res.data_byte    = byte_val;
    res.offset       = index_r[3:0];
    res.load_address = addr_r;
    res.rec_type     = type_r;
    res.length       = count_r;
    res.status       = ST_CSUM_OK;

    if (in_take) begin
      if (phase_r == PH_WAIT) begin
        if (in_char_in == CHAR_START) begin
          digit_phase_nxt = 1'b0;
          high_nibble_nxt = 4'd0;
          sum_nxt         = 8'd0;
          index_nxt       = 8'd0;
        end
      end else if (!digit_phase_r) begin
        high_nibble_nxt = nib;
        digit_phase_nxt = 1'b1;
      end else begin
        digit_phase_nxt = 1'b0;
        sum_nxt         = sum_r + byte_val;
        unique case (phase_r)
          PH_COUNT:  count_nxt = byte_val;
          PH_ADDRHI: addr_nxt  = {byte_val, 8'd0};
          PH_ADDRLO: addr_nxt  = {addr_r[15:8], byte_val};
          PH_TYPE: begin
            type_nxt  = byte_val;
            index_nxt = 8'd0;
          end
          PH_DATA: begin
            index_nxt = index_inc;
            res_valid = (index_r < MaxData);
          end
          default: begin
            // checksum byte: close the record
            res.kind      = KIND_RECORD;
            res.data_byte = 8'd0;
            res.offset    = 4'd0;
            if (count_r > MaxData)         res.status = ST_OVERLONG;
            else if (sum_r + byte_val == 8'd0) res.status = ST_CSUM_OK;
            else                           res.status = ST_CSUM_ERR;
            res_valid = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_WAIT;
      high_nibble_r <= 4'd0;
      digit_phase_r <= 1'b0;
      count_r       <= 8'd0;
      addr_r        <= 16'd0;
      type_r        <= 8'd0;
      sum_r         <= 8'd0;
      index_r       <= 8'd0;
    end else begin
      phase_r       <= phase_nxt;
      high_nibble_r <= high_nibble_nxt;
      digit_phase_r <= digit_phase_nxt;
      count_r       <= count_nxt;
      addr_r        <= addr_nxt;
      type_r        <= type_nxt;
      sum_r         <= sum_nxt;
      index_r       <= index_nxt;
    end
  end

  // Output register with one skid slot behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        // in_stall held input off, so no new result this cycle
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take) begin
      if (skid_valid_r) out_r <= skid_r;
      else if (res_valid) out_r <= res;
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_r.kind;
  assign out_data_byte    = out_r.data_byte;
  assign out_offset       = out_r.offset;
  assign out_load_address = out_r.load_address;
  assign out_rec_type     = out_r.rec_type;
  assign out_length       = out_r.length;
  assign out_status       = out_r.status;

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for hex_record_parser. Characters are fed one word at
// a time: a short table of hand-written records first, then random records
// (mostly well-formed, some with bad checksums, overlong counts, stray
// characters or cut short) with noise between them. A cycle-accurate-free
// shadow of the parser predicts every data byte and record status word, and
// each word leaving the block is compared field by field against the oldest
// prediction. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench import hrp_pkg::*; ();

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 8;
  localparam int TARGET_CHARS = 1100;    // parsed characters, dropped ones excluded
  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 300;     // receiver hold-off, long enough to back up input
  localparam int DRAIN_CYCLES = 16;      // covers the output register plus the skid slot
  localparam int SHOWN_FAULTS = 10;
  localparam int DIR_ROWS     = 27;

  localparam logic [7:0] UPPER_A = "A";
  localparam logic [7:0] LOWER_A = "a";
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam result_t NO_WORD = '0;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [7:0]  in_char_in = 8'h00;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic        out_kind;
  logic [7:0]  out_data_byte;
  logic [3:0]  out_offset;
  logic [15:0] out_load_address;
  logic [7:0]  out_rec_type;
  logic [7:0]  out_length;
  logic [1:0]  out_status;

  always #HALF_PERIOD clk = ~clk;

  hex_record_parser DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_in       (in_char_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_data_byte    (out_data_byte),
    .out_offset       (out_offset),
    .out_load_address (out_load_address),
    .out_rec_type     (out_rec_type),
    .out_length       (out_length),
    .out_status       (out_status)
  );

  // Words still owed by the block, oldest first.
  result_t awaited_words[$];

  int fault_count   = 0;
  int parsed_chars  = 0;
  int cycle_count   = 0;
  int hold_requests = 0;   // bumped by the sender, served by the receiver
  bit tx_steady     = 1'b0;
  bit rx_steady     = 1'b0;

  // --------------------------------------------------------------------------
  // Shadow of the parser state
  // --------------------------------------------------------------------------
  phase_t      trk_phase  = PH_WAIT;
  logic [3:0]  trk_high   = '0;
  logic        trk_second = 1'b0;   // next character completes a byte
  logic [7:0]  trk_count  = '0;
  logic [15:0] trk_addr   = '0;
  logic [7:0]  trk_type   = '0;
  logic [7:0]  trk_sum    = '0;
  logic [7:0]  trk_index  = '0;

  // Advance the shadow by one character; flags and returns the word it yields.
  function automatic void decode_char(input logic [7:0] c, output logic made,
                                      output result_t word);
    logic [7:0] d;
    logic [7:0] b;
    logic [7:0] idx;
    made = 1'b0;
    word = NO_WORD;
    // any character is a digit inside a record, hex or not
    d = (c <= CHAR_NINE) ? c - CHAR_ZERO : c - ALPHA_BIAS;
    if (trk_phase == PH_WAIT) begin
      if (c == CHAR_START) begin
        trk_phase  = PH_COUNT;
        trk_second = 1'b0;
        trk_high   = '0;
        trk_sum    = '0;
        trk_index  = '0;
      end
      return;
    end
    if (!trk_second) begin
      trk_high   = d[3:0];
      trk_second = 1'b1;
      return;
    end
    trk_second = 1'b0;
    b          = {trk_high, d[3:0]};
    trk_sum    = trk_sum + b;
    case (trk_phase)
      PH_COUNT: begin
        trk_count = b;
        trk_phase = PH_ADDRHI;
      end
      PH_ADDRHI: begin
        trk_addr  = {b, 8'h00};
        trk_phase = PH_ADDRLO;
      end
      PH_ADDRLO: begin
        trk_addr[7:0] = b;
        trk_phase     = PH_TYPE;
      end
      PH_TYPE: begin
        trk_type  = b;
        trk_index = '0;
        trk_phase = (trk_count == 8'd0) ? PH_CSUM : PH_DATA;
      end
      PH_DATA: begin
        idx       = trk_index;
        trk_index = trk_index + 8'd1;
        if (trk_index >= trk_count) trk_phase = PH_CSUM;
        // overlong records still sum every byte but only emit the first HRP_MAX_DATA
        if (idx < HRP_MAX_DATA) begin
          made = 1'b1;
          word = '{KIND_DATA, b, idx[3:0], trk_addr, trk_type, trk_count, ST_CSUM_OK};
        end
      end
      default: begin
        made = 1'b1;
        word = '{KIND_RECORD, 8'h00, 4'h0, trk_addr, trk_type, trk_count, ST_CSUM_OK};
        if (trk_count > HRP_MAX_DATA) word.status = ST_OVERLONG;
        else if (trk_sum != 8'd0)     word.status = ST_CSUM_ERR;
        trk_phase = PH_WAIT;
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Directed table. Rows with a typed word are checked against that word;
  // the rest are left to the shadow.
  // --------------------------------------------------------------------------
  typedef struct {
    logic [7:0] ch;
    logic       typed;
    result_t    want;
  } dir_row_t;

  dir_row_t dir_table [DIR_ROWS] = '{
    '{"x",   1'b0, NO_WORD},   // idle: dropped
    '{8'hFF, 1'b0, NO_WORD},   // idle: top code, dropped
    '{8'h00, 1'b0, NO_WORD},   // idle: bottom code, dropped
    // end-of-file record, zero byte count, checksum straight after type
    '{":",   1'b0, NO_WORD},
    '{"0",   1'b0, NO_WORD}, '{"0", 1'b0, NO_WORD},
    '{"0",   1'b0, NO_WORD}, '{"0", 1'b0, NO_WORD},
    '{"0",   1'b0, NO_WORD}, '{"0", 1'b0, NO_WORD},
    '{"0",   1'b0, NO_WORD}, '{"1", 1'b0, NO_WORD},
    '{"F",   1'b0, NO_WORD},
    '{"F",   1'b1, '{KIND_RECORD, 8'h00, 4'h0, 16'h0000, 8'h01, 8'h00, ST_CSUM_OK}},
    // one byte at the top address, mixed case digits, bad checksum
    '{":",   1'b0, NO_WORD},
    '{"0",   1'b0, NO_WORD}, '{"1", 1'b0, NO_WORD},
    '{"F",   1'b0, NO_WORD}, '{"F", 1'b0, NO_WORD},
    '{"f",   1'b0, NO_WORD}, '{"f", 1'b0, NO_WORD},
    '{"0",   1'b0, NO_WORD}, '{"0", 1'b0, NO_WORD},
    '{"F",   1'b0, NO_WORD},
    '{"f",   1'b1, '{KIND_DATA, 8'hFF, 4'h0, 16'hFFFF, 8'h00, 8'h01, ST_CSUM_OK}},
    '{"0",   1'b0, NO_WORD},
    // ':' inside a record decodes as digit 3: sum lands on 01, not zero
    '{":",   1'b1, '{KIND_RECORD, 8'h00, 4'h0, 16'hFFFF, 8'h00, 8'h01, ST_CSUM_ERR}}
  };

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  // Offer one character, wait for the handshake, then log what it should cause.
  task automatic send_char(input logic [7:0] c, input logic typed, input result_t want);
    int      gap;
    logic    made;
    result_t word;
    gap = tx_steady ? 0 : $urandom_range(0, 9);
    if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_char_in <= c;
    do @(posedge clk); while (in_stall);
    if (trk_phase != PH_WAIT || c == CHAR_START) parsed_chars++;
    decode_char(c, made, word);
    if (typed)     awaited_words.push_back(want);
    else if (made) awaited_words.push_back(word);
  endtask

  // One random record: mostly legal, with some bad checksums, overlong
  // counts, stray digits and early cut-offs, then some line noise.
  task automatic send_record();
    int         r;
    int         i;
    int         cut;
    int         noise;
    logic [7:0] cnt;
    logic [7:0] sum;
    logic [7:0] b;
    logic [3:0] nib;
    logic [7:0] ch;
    logic [7:0] rec_bytes[$];
    r = $urandom_range(0, 99);
    if (r < 3)       cnt = 8'($urandom_range(128, 255));
    else if (r < 20) cnt = 8'($urandom_range(HRP_MAX_DATA + 1, 40));
    else             cnt = 8'($urandom_range(0, HRP_MAX_DATA));
    rec_bytes.push_back(cnt);
    rec_bytes.push_back(8'($urandom_range(0, 255)));
    rec_bytes.push_back(8'($urandom_range(0, 255)));
    rec_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(0, 5)));
    repeat (cnt) rec_bytes.push_back(8'($urandom_range(0, 255)));
    sum = '0;
    foreach (rec_bytes[k]) sum = sum + rec_bytes[k];
    b = 8'd0 - sum;
    if ($urandom_range(0, 4) == 0) b = b + 8'($urandom_range(1, 255));
    rec_bytes.push_back(b);

    cut = 2 * rec_bytes.size();
    if ($urandom_range(0, 9) == 0) cut = $urandom_range(0, cut - 1);

    send_char(CHAR_START, 1'b0, NO_WORD);
    for (i = 0; i < cut; i++) begin
      b   = rec_bytes[i / 2];
      nib = (i % 2 == 0) ? b[7:4] : b[3:0];
      r   = $urandom_range(0, 63);
      if (r == 0)       ch = 8'($urandom_range(0, 255));   // stray character
      else if (nib < 10) ch = CHAR_ZERO + nib;
      else if (r[0])     ch = LOWER_A + (nib - 4'd10);
      else               ch = UPPER_A + (nib - 4'd10);
      send_char(ch, 1'b0, NO_WORD);
    end

    noise = $urandom_range(0, 3);
    repeat (noise) begin
      case ($urandom_range(0, 3))
        0:       ch = CHAR_CR;
        1:       ch = CHAR_LF;
        default: ch = 8'($urandom_range(0, 255));
      endcase
      send_char(ch, 1'b0, NO_WORD);
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver and checker
  // --------------------------------------------------------------------------
  task automatic report_fault(input string what, input result_t want, input result_t got);
    if (fault_count < SHOWN_FAULTS) begin
      $display("%0t %s", $time, what);
      $display("  want kind=%0d byte=%02h off=%0d addr=%04h type=%02h len=%02h st=%0d",
               want.kind, want.data_byte, want.offset, want.load_address,
               want.rec_type, want.length, want.status);
      $display("  got  kind=%0d byte=%02h off=%0d addr=%04h type=%02h len=%02h st=%0d",
               got.kind, got.data_byte, got.offset, got.load_address,
               got.rec_type, got.length, got.status);
    end
    fault_count++;
  endtask

  initial begin
    int      hold_left;
    int      long_left;
    int      served;
    result_t got;
    result_t want;
    hold_left = 0;
    long_left = 0;
    served    = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        got = '{out_kind, out_data_byte, out_offset, out_load_address,
                out_rec_type, out_length, out_status};
        if (awaited_words.size() == 0) begin
          report_fault("word with nothing awaited", NO_WORD, got);
        end else begin
          want = awaited_words.pop_front();
          if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
              got.offset !== want.offset || got.load_address !== want.load_address ||
              got.rec_type !== want.rec_type || got.length !== want.length ||
              got.status !== want.status) begin
            report_fault("word mismatch", want, got);
          end
        end
        // stall before the next word, with runs of no stalling at all
        hold_left = rx_steady ? 0 : $urandom_range(0, 9);
        if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
      end
      if (hold_requests != served) begin
        served    = hold_requests;
        long_left = LONG_HOLD;
      end
      if (long_left > 0) begin
        long_left--;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("hex_record_parser verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int rec_no;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_table[i]) send_char(dir_table[i].ch, dir_table[i].typed, dir_table[i].want);

    rec_no = 0;
    while (parsed_chars < TARGET_CHARS) begin
      // long receiver hold-off while we keep pushing: the skid fills and
      // in_stall has to rise; early enough that even two longest records
      // cannot end the run before it
      if (rec_no % 25 == 1) hold_requests <= hold_requests + 1;
      // quiet the input until every owed word is out
      if (rec_no % 25 == 2) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (awaited_words.size() != 0);
      end
      send_record();
      rec_no++;
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_words.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);   // catch any stray extra words

    if (fault_count == 0) begin
      $display("hex_record_parser verification clean");
    end else begin
      $display("hex_record_parser verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/hrp_pkg.sv
src/hex_record_parser.sv
tb/testbench.sv
